// ===== hw/rtl/oce_pkg.sv =====
// ----------------------------------------------------------------------------
// Orbit camera eye position: shared package
// Types, constants and helper functions used by the orbit camera core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oce_pkg;

   localparam int CORDIC_STEPS     = 16;
   localparam int CORDIC_STEPS_EFF = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

   localparam int FULL_TURN    = 46080;
   localparam int HALF_TURN    = 23040;
   localparam int QUARTER_TURN = 11520;
   localparam int ELEV_LIMIT   = 11392;
   localparam int DIST_MIN     = 512;
   localparam int DIST_MAX     = 10240;
   localparam int AZ_RESET     = 5760;
   localparam int EL_RESET     = 3200;
   localparam int DIST_RESET   = 2560;
   localparam int CORDIC_GAIN  = 652032874;

   typedef enum logic [1:0] {
      CMD_ORBIT = 2'd0,
      CMD_ZOOM  = 2'd1,
      CMD_MOVE  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AZ_START,
      ST_AZ_WAIT,
      ST_MV0,
      ST_MV1,
      ST_MV2,
      ST_MV3,
      ST_MV4,
      ST_EL_START,
      ST_EL_WAIT,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic signed [16:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } cordic_rsp_type;

   // atan(2^-i) in units of 2^-20 degree.
   function automatic logic [25:0] atan_lookup(input logic [4:0] idx);
      logic [25:0] v;
      case (idx)
         5'd0:    v = 26'd47185920;
         5'd1:    v = 26'd27855475;
         5'd2:    v = 26'd14718068;
         5'd3:    v = 26'd7471121;
         5'd4:    v = 26'd3750058;
         5'd5:    v = 26'd1876857;
         5'd6:    v = 26'd938658;
         5'd7:    v = 26'd469357;
         5'd8:    v = 26'd234682;
         5'd9:    v = 26'd117342;
         5'd10:   v = 26'd58671;
         5'd11:   v = 26'd29335;
         5'd12:   v = 26'd14668;
         5'd13:   v = 26'd7334;
         5'd14:   v = 26'd3667;
         5'd15:   v = 26'd1833;
         5'd16:   v = 26'd917;
         5'd17:   v = 26'd458;
         5'd18:   v = 26'd229;
         5'd19:   v = 26'd115;
         5'd20:   v = 26'd57;
         5'd21:   v = 26'd29;
         5'd22:   v = 26'd14;
         5'd23:   v = 26'd7;
         default: v = 26'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/oce_mul.sv =====
// ----------------------------------------------------------------------------
// Orbit camera: shared multiplier
// Signed 32 by 32 multiplier with a registered product, shared by all multiply steps of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oce_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] product
);

   logic signed [63:0] product_ff;
   logic signed [63:0] product_in;

   assign product_in = op_a * op_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== hw/rtl/oce_cordic.sv =====
// ----------------------------------------------------------------------------
// Orbit camera: iterative CORDIC
// Rotation-mode CORDIC giving sine and cosine in Q2.30, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oce_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  oce_pkg::cordic_req_type req,
   output oce_pkg::cordic_rsp_type rsp
);

   import oce_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               flip_ff, flip_in;
   logic [4:0]         step_ff, step_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [31:0] cos_ff, cos_in;

   logic signed [17:0] a0, a1;
   logic               flip0;
   logic signed [31:0] xs, ys, xn, yn, zn, at;

   always_comb begin
      a0    = {req.angle[16], req.angle};
      flip0 = 1'b0;
      if (a0 >= 18'(HALF_TURN)) begin
         a0 = a0 - 18'(FULL_TURN);
      end
      if (a0 < -18'sd23040) begin
         a0 = a0 + 18'(FULL_TURN);
      end
      a1 = a0;
      if (a0 > 18'(QUARTER_TURN)) begin
         a1    = a0 - 18'(HALF_TURN);
         flip0 = 1'b1;
      end else if (a0 < -18'sd11520) begin
         a1    = a0 + 18'(HALF_TURN);
         flip0 = 1'b1;
      end
   end

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = {6'b0, atan_lookup(step_ff)};
      if (!z_ff[31]) begin
         xn = x_ff - ys;
         yn = y_ff + xs;
         zn = z_ff - at;
      end else begin
         xn = x_ff + ys;
         yn = y_ff - xs;
         zn = z_ff + at;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (req.start) begin
         busy_in = 1'b1;
         flip_in = flip0;
         step_in = 5'd0;
         x_in    = 32'(CORDIC_GAIN);
         y_in    = 32'sd0;
         z_in    = {{14{a1[17]}}, a1} <<< 13;
      end else if (busy_ff) begin
         x_in    = xn;
         y_in    = yn;
         z_in    = zn;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS_EFF - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            sin_in  = flip_ff ? -yn : yn;
            cos_in  = flip_ff ? -xn : xn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign rsp.done = done_ff;
   assign rsp.sin  = sin_ff;
   assign rsp.cos  = cos_ff;

endmodule

// ===== hw/rtl/orbit_camera_eye_position_core.sv =====
// ----------------------------------------------------------------------------
// Orbit camera eye position core
// Keeps the orbit camera state and returns the eye position after each request.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries a command in req_tuser (orbit, zoom,
// move or reset) and its operands in req_tdata. The block updates azimuth,
// elevation, distance and target, then returns one response on the rsp_
// channel holding the eye position and the current target, all Q16.8.
// Each request takes two CORDIC runs of 16 steps each on the single CORDIC
// unit plus four or eight passes (eight for a move) through the one shared
// multiplier; the next request is not accepted until the response is loaded.
// req_tready is high only while the sequencer is idle.
// The response is held in an output register; a stalled receiver holds the
// finished response and the sequencer waits before loading the next one.
// Synchronous reset restores 45 degrees azimuth, 25 degrees elevation,
// distance 10.0 and a zero target, and drops any pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orbit_camera_eye_position_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // delta_azimuth, delta_elevation, zoom_step, move_forward, move_right, pad
   input  logic [79:0]   req_tdata,
   // command
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // eye_x, eye_y, eye_z, look_x, look_z
   output logic [119:0]  rsp_tdata
);

   import oce_pkg::*;

   state_type state_ff, state_in;

   cmd_type            cmd_ff, cmd_in;
   logic signed [15:0] da_ff, da_in;
   logic signed [15:0] de_ff, de_in;
   logic signed [14:0] zs_ff, zs_in;
   logic signed [15:0] mf_ff, mf_in;
   logic signed [15:0] mr_ff, mr_in;

   logic [15:0]        az_ff, az_in;
   logic signed [14:0] el_ff, el_in;
   logic [13:0]        dist_ff, dist_in;
   logic signed [23:0] tx_ff, tx_in;
   logic signed [23:0] tz_ff, tz_in;

   logic signed [31:0] sa_ff, sa_in;
   logic signed [31:0] ca_ff, ca_in;
   logic signed [31:0] se_ff, se_in;
   logic signed [31:0] ce_ff, ce_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [29:0] h_ff, h_in;
   logic signed [23:0] ex_ff, ex_in;
   logic signed [23:0] ey_ff, ey_in;
   logic signed [23:0] ez_ff, ez_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] product;
   cordic_req_type     cordic_req;
   cordic_rsp_type     cordic_rsp;

   logic signed [17:0] az_sum;
   logic signed [16:0] el_sum;
   logic signed [16:0] dist_sum;
   logic signed [49:0] mv_sum;
   logic signed [63:0] rnd;
   logic               req_fire, load_rsp;

   assign req_fire   = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   oce_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   oce_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) begin state_in = ST_UPDATE; end
         ST_UPDATE:   state_in = ST_AZ_START;
         ST_AZ_START: state_in = ST_AZ_WAIT;
         ST_AZ_WAIT: begin
            if (cordic_rsp.done) begin
               state_in = (cmd_ff == CMD_MOVE) ? ST_MV0 : ST_EL_START;
            end
         end
         ST_MV0:      state_in = ST_MV1;
         ST_MV1:      state_in = ST_MV2;
         ST_MV2:      state_in = ST_MV3;
         ST_MV3:      state_in = ST_MV4;
         ST_MV4:      state_in = ST_EL_START;
         ST_EL_START: state_in = ST_EL_WAIT;
         ST_EL_WAIT:  if (cordic_rsp.done) begin state_in = ST_F0; end
         ST_F0:       state_in = ST_F1;
         ST_F1:       state_in = ST_F2;
         ST_F2:       state_in = ST_F3;
         ST_F3:       state_in = ST_F4;
         ST_F4:       state_in = ST_DONE;
         ST_DONE:     if (load_rsp) begin state_in = ST_IDLE; end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cordic_req.start = 1'b0;
      cordic_req.angle = {1'b0, az_ff};
      mul_a            = 32'sd0;
      mul_b            = 32'sd0;
      case (state_ff)
         ST_AZ_START: cordic_req.start = 1'b1;
         ST_EL_START: begin
            cordic_req.start = 1'b1;
            cordic_req.angle = {{2{el_ff[14]}}, el_ff};
         end
         ST_MV0: begin mul_a = {{16{mf_ff[15]}}, mf_ff}; mul_b = sa_ff; end
         ST_MV1: begin mul_a = {{16{mr_ff[15]}}, mr_ff}; mul_b = ca_ff; end
         ST_MV2: begin mul_a = {{16{mf_ff[15]}}, mf_ff}; mul_b = ca_ff; end
         ST_MV3: begin mul_a = {{16{mr_ff[15]}}, mr_ff}; mul_b = sa_ff; end
         ST_F0:  begin mul_a = {18'b0, dist_ff}; mul_b = ce_ff; end
         ST_F1:  begin mul_a = {18'b0, dist_ff}; mul_b = se_ff; end
         ST_F2:  begin mul_a = {{2{h_in[29]}}, h_in}; mul_b = sa_ff; end
         ST_F3:  begin mul_a = {{2{h_ff[29]}}, h_ff}; mul_b = ca_ff; end
         default: begin
            mul_a = 32'sd0;
            mul_b = 32'sd0;
         end
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      da_in   = da_ff;
      de_in   = de_ff;
      zs_in   = zs_ff;
      mf_in   = mf_ff;
      mr_in   = mr_ff;
      az_in   = az_ff;
      el_in   = el_ff;
      dist_in = dist_ff;
      tx_in   = tx_ff;
      tz_in   = tz_ff;
      sa_in   = sa_ff;
      ca_in   = ca_ff;
      se_in   = se_ff;
      ce_in   = ce_ff;
      acc_in  = acc_ff;
      h_in    = h_ff;
      ex_in   = ex_ff;
      ey_in   = ey_ff;
      ez_in   = ez_ff;
      rnd     = 64'sd0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      az_sum   = $signed({2'b0, az_ff}) + {{2{da_ff[15]}}, da_ff};
      el_sum   = {{2{el_ff[14]}}, el_ff} + {de_ff[15], de_ff};
      dist_sum = $signed({3'b0, dist_ff}) - {{2{zs_ff[14]}}, zs_ff};
      mv_sum   = 50'sd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in = cmd_type'(req_tuser);
               da_in  = req_tdata[15:0];
               de_in  = req_tdata[31:16];
               zs_in  = req_tdata[46:32];
               mf_in  = req_tdata[62:47];
               mr_in  = req_tdata[78:63];
            end
         end
         ST_UPDATE: begin
            case (cmd_ff)
               CMD_ORBIT: begin
                  if (az_sum < 18'sd0) begin
                     az_sum = az_sum + 18'(FULL_TURN);
                  end
                  if (az_sum >= 18'(FULL_TURN)) begin
                     az_sum = az_sum - 18'(FULL_TURN);
                  end
                  az_in = az_sum[15:0];
                  if (el_sum > 17'(ELEV_LIMIT)) begin
                     el_in = 15'(ELEV_LIMIT);
                  end else if (el_sum < -17'sd11392) begin
                     el_in = -15'sd11392;
                  end else begin
                     el_in = el_sum[14:0];
                  end
               end
               CMD_ZOOM: begin
                  if (dist_sum < 17'(DIST_MIN)) begin
                     dist_in = 14'(DIST_MIN);
                  end else if (dist_sum > 17'(DIST_MAX)) begin
                     dist_in = 14'(DIST_MAX);
                  end else begin
                     dist_in = dist_sum[13:0];
                  end
               end
               CMD_RESET: begin
                  az_in   = 16'(AZ_RESET);
                  el_in   = 15'(EL_RESET);
                  dist_in = 14'(DIST_RESET);
                  tx_in   = 24'sd0;
                  tz_in   = 24'sd0;
               end
               default: begin
                  az_in = az_ff;
               end
            endcase
         end
         ST_AZ_WAIT: begin
            if (cordic_rsp.done) begin
               sa_in = cordic_rsp.sin;
               ca_in = cordic_rsp.cos;
            end
         end
         ST_EL_WAIT: begin
            if (cordic_rsp.done) begin
               se_in = cordic_rsp.sin;
               ce_in = cordic_rsp.cos;
            end
         end
         ST_MV1: acc_in = -product[49:0];
         ST_MV2: begin
            mv_sum = acc_ff + product[49:0];
            rnd    = ($signed({{14{mv_sum[49]}}, mv_sum}) + (64'sd1 <<< 29)) >>> 30;
            tx_in  = sat24({{40{tx_ff[23]}}, tx_ff} + rnd);
         end
         ST_MV3: acc_in = -product[49:0];
         ST_MV4: begin
            mv_sum = acc_ff - product[49:0];
            rnd    = ($signed({{14{mv_sum[49]}}, mv_sum}) + (64'sd1 <<< 29)) >>> 30;
            tz_in  = sat24({{40{tz_ff[23]}}, tz_ff} + rnd);
         end
         ST_F1: begin
            rnd  = (product + (64'sd1 <<< 14)) >>> 15;
            h_in = rnd[29:0];
         end
         ST_F2: begin
            rnd   = (product + (64'sd1 <<< 29)) >>> 30;
            ey_in = sat24(rnd);
         end
         ST_F3: begin
            rnd   = (product + (64'sd1 <<< 44)) >>> 45;
            ex_in = sat24({{40{tx_ff[23]}}, tx_ff} + rnd);
         end
         ST_F4: begin
            rnd   = (product + (64'sd1 <<< 44)) >>> 45;
            ez_in = sat24({{40{tz_ff[23]}}, tz_ff} + rnd);
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tz_ff, tx_ff, ez_ff, ey_ff, ex_ff};
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         az_ff        <= 16'(AZ_RESET);
         el_ff        <= 15'(EL_RESET);
         dist_ff      <= 14'(DIST_RESET);
         tx_ff        <= 24'sd0;
         tz_ff        <= 24'sd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         az_ff        <= az_in;
         el_ff        <= el_in;
         dist_ff      <= dist_in;
         tx_ff        <= tx_in;
         tz_ff        <= tz_in;
      end
      cmd_ff      <= cmd_in;
      da_ff       <= da_in;
      de_ff       <= de_in;
      zs_ff       <= zs_in;
      mf_ff       <= mf_in;
      mr_ff       <= mr_in;
      sa_ff       <= sa_in;
      ca_ff       <= ca_in;
      se_ff       <= se_in;
      ce_ff       <= ce_in;
      acc_ff      <= acc_in;
      h_ff        <= h_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      ez_ff       <= ez_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/oce_checker.sv =====
// ----------------------------------------------------------------------------
// Orbit camera: port checker
// Concurrent checks on the ports of the orbit camera core, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oce_port_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Core accepted a request on the cycle after another one.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("Reset did not drop the response and return to idle.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed or was dropped.");

   a_eye_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[47:24]) <= 24'sd10300 &&
                      $signed(rsp_tdata[47:24]) >= -24'sd10300))
      else $error("Eye height exceeds the largest orbit distance.");

endmodule

bind orbit_camera_eye_position_core oce_port_checker u_oce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
